// ===== sv/ecd_pkg.sv =====
// ============================================================================
// ecd_pkg
// Shared types, constants and calendar helpers for the epoch/date converter.
// ============================================================================
`timescale 1ns / 1ps

package ecd_pkg;

    // Register stages from input transfer to result register
    localparam int PIPE_DEPTH = 7;

    typedef enum logic [1:0] {
        ACT_TO_DATE     = 2'd0,
        ACT_TO_SECS     = 2'd1,
        ACT_TO_SECS_CHK = 2'd2,
        ACT_NONE        = 2'd3
    } action_t;

    localparam logic [15:0] EPOCH_YEAR = 16'd1978;
    localparam logic [11:0] EPOCH_YEAR12 = 12'd1978;
    // leaps_upto(1977)
    localparam logic [13:0] EPOCH_LEAPS = 14'd479;

    // Reciprocal multipliers (floor or ceil of 2^k / divisor)
    localparam logic [25:0] RCP_675 = 26'd50903316;   // k = 35, floor
    localparam logic [11:0] RCP_YEAR = 12'd2870;      // k = 20, floor of 2^k/365.25
    localparam logic [12:0] RCP_3600 = 13'd4660;      // k = 24, floor
    localparam logic [16:0] RCP_60 = 17'd69905;       // k = 22, floor
    localparam logic [16:0] RCP_7 = 17'd74898;        // k = 19, floor
    localparam logic [14:0] RCP_25 = 15'd20972;       // k = 19, ceil, exact below 2^14

    // Days in the months before the given one (non-leap)
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of a month (non-leap)
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] d;
        case (month)
            4'd2:    d = 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

    // First day of year 1978+ofs, counted from the epoch (ofs up to 138)
    function automatic logic [16:0] year_start(input logic [7:0] ofs);
        logic [16:0] base;
        logic [6:0]  lp;
        base = 17'(ofs) * 17'd365;
        lp   = 7'((9'(ofs) + 9'd1) >> 2);
        // 2100 is not a leap year
        if (ofs >= 8'd123)
            lp = lp - 7'd1;
        return base + 17'(lp);
    endfunction

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
    } date_t;

    typedef struct packed {
        logic [31:0] seconds;
        logic        ok;
    } secs_res_t;

endpackage

// ===== sv/epoch_seconds_date_convert.sv =====
// ============================================================================
// epoch_seconds_date_convert
// Seconds since 1978-01-01 to Gregorian calendar date and back.
// ============================================================================
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  input    in_valid / in_ready    action, in_seconds, in_second .. in_weekday
//  output   out_valid / out_ready  out_seconds, out_second .. out_weekday,
//                                  valid_res
//
//  Items pass all stages from input transfer to result available; one may
//  enter each cycle the output is not held, so sustained rate is one per
//  clock without stalls. Depth is set by the date path's constant-division
//  and year-selection stages. Reset clears only the stage valid bits. A held
//  result stalls all stages together; nothing is dropped or repeated.
//
`timescale 1ns / 1ps

module epoch_seconds_date_convert
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] in_seconds,
    input  logic [15:0] in_second,
    input  logic [15:0] in_minute,
    input  logic [15:0] in_hour,
    input  logic [15:0] in_day,
    input  logic [15:0] in_month,
    input  logic [15:0] in_year,
    input  logic [15:0] in_weekday,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_seconds,
    output logic [5:0]  out_second,
    output logic [5:0]  out_minute,
    output logic [4:0]  out_hour,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [11:0] out_year,
    output logic [2:0]  out_weekday,
    output logic        valid_res
);

    localparam int D = ecd_pkg::PIPE_DEPTH;

    logic               adv;
    logic [D-1:0]       valid_reg;
    logic [1:0]         act_reg [D];
    ecd_pkg::date_t     date;
    ecd_pkg::secs_res_t jres;

    // Whole pipe moves unless the last stage holds an untaken result
    assign adv      = !valid_reg[D-1] || out_ready;
    assign in_ready = adv;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[D-2:0], in_valid};
    end

    // Action code travels alongside the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act_reg[0] <= action;
            for (int i = 1; i < D; i++)
                act_reg[i] <= act_reg[i-1];
        end
    end

    ecd_split u_split
    (
        .clk     (clk),
        .en      (adv),
        .seconds (in_seconds),
        .date    (date)
    );

    ecd_join u_join
    (
        .clk     (clk),
        .en      (adv),
        .action  (action),
        .second  (in_second),
        .minute  (in_minute),
        .hour    (in_hour),
        .day     (in_day),
        .month   (in_month),
        .year    (in_year),
        .weekday (in_weekday),
        .res     (jres)
    );

    assign out_valid = valid_reg[D-1];

    // Result select by action
    always_comb
    begin
        out_seconds = 32'd0;
        out_second  = 6'd0;
        out_minute  = 6'd0;
        out_hour    = 5'd0;
        out_day     = 5'd0;
        out_month   = 4'd0;
        out_year    = 12'd0;
        out_weekday = 3'd0;
        valid_res   = 1'b0;
        case (ecd_pkg::action_t'(act_reg[D-1]))
            ecd_pkg::ACT_TO_DATE:
            begin
                out_second  = date.second;
                out_minute  = date.minute;
                out_hour    = date.hour;
                out_day     = date.day;
                out_month   = date.month;
                out_year    = date.year;
                out_weekday = date.weekday;
                valid_res   = 1'b1;
            end
            ecd_pkg::ACT_TO_SECS,
            ecd_pkg::ACT_TO_SECS_CHK:
            begin
                out_seconds = jres.seconds;
                valid_res   = jres.ok;
            end
            default:
            begin
                valid_res = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/ecd_split.sv =====
// ============================================================================
// ecd_split
// Seconds count to calendar fields, seven register stages.
// ============================================================================
`timescale 1ns / 1ps

module ecd_split
(
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   seconds,
    output ecd_pkg::date_t date
);

    // ---------------- stage 1: day estimate (seconds/128/675)
    logic [50:0] p1_prod;
    logic [24:0] s1_s7_reg;
    logic [6:0]  s1_low_reg;
    logic [15:0] s1_qe_reg;

    assign p1_prod = 51'(seconds[31:7]) * 51'(ecd_pkg::RCP_675);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_s7_reg  <= seconds[31:7];
            s1_low_reg <= seconds[6:0];
            s1_qe_reg  <= p1_prod[50:35];
        end
    end

    // ---------------- stage 2: remainder of the estimate
    logic [25:0] p2_prod;
    logic [24:0] p2_diff;
    logic [15:0] s2_qe_reg;
    logic [10:0] s2_r_reg;
    logic [6:0]  s2_low_reg;

    assign p2_prod = 26'(s1_qe_reg) * 26'd675;
    assign p2_diff = s1_s7_reg - p2_prod[24:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_qe_reg  <= s1_qe_reg;
            s2_r_reg   <= p2_diff[10:0];
            s2_low_reg <= s1_low_reg;
        end
    end

    // ---------------- stage 3: correct day count, seconds of day
    logic [15:0] p3_days;
    logic [10:0] p3_r;
    logic [15:0] s3_days_reg;
    logic [16:0] s3_rem_reg;

    always_comb
    begin
        if (s2_r_reg >= 11'd675)
        begin
            p3_days = s2_qe_reg + 16'd1;
            p3_r    = s2_r_reg - 11'd675;
        end
        else
        begin
            p3_days = s2_qe_reg;
            p3_r    = s2_r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_days_reg <= p3_days;
            s3_rem_reg  <= {p3_r[9:0], s2_low_reg};
        end
    end

    // ---------------- stage 4: year, minute, hour and week estimates
    logic [27:0] p4_yprod;
    logic [29:0] p4_hprod;
    logic [33:0] p4_mprod;
    logic [32:0] p4_wprod;
    logic [15:0] s4_days_reg;
    logic [16:0] s4_rem_reg;
    logic [7:0]  s4_yest_reg;
    logic [4:0]  s4_hest_reg;
    logic [10:0] s4_mest_reg;
    logic [13:0] s4_west_reg;

    assign p4_yprod = 28'(s3_days_reg) * 28'(ecd_pkg::RCP_YEAR);
    assign p4_hprod = 30'(s3_rem_reg) * 30'(ecd_pkg::RCP_3600);
    assign p4_mprod = 34'(s3_rem_reg) * 34'(ecd_pkg::RCP_60);
    assign p4_wprod = 33'(s3_days_reg) * 33'(ecd_pkg::RCP_7);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_days_reg <= s3_days_reg;
            s4_rem_reg  <= s3_rem_reg;
            s4_yest_reg <= p4_yprod[27:20];
            s4_hest_reg <= p4_hprod[28:24];
            s4_mest_reg <= p4_mprod[32:22];
            s4_west_reg <= p4_wprod[32:19];
        end
    end

    // ---------------- stage 5: candidate year starts, remainders
    logic [16:0] p5_hdiff;
    logic [16:0] p5_mdiff;
    logic [15:0] p5_wdiff;
    logic [15:0] s5_days_reg;
    logic [7:0]  s5_yest_reg;
    logic [16:0] s5_st0_reg;
    logic [16:0] s5_st1_reg;
    logic [16:0] s5_st2_reg;
    logic [4:0]  s5_hest_reg;
    logic [12:0] s5_hr_reg;
    logic [10:0] s5_mest_reg;
    logic [6:0]  s5_sr_reg;
    logic [3:0]  s5_wr_reg;

    assign p5_hdiff = s4_rem_reg - 17'(s4_hest_reg) * 17'd3600;
    assign p5_mdiff = s4_rem_reg - 17'(s4_mest_reg) * 17'd60;
    assign p5_wdiff = s4_days_reg - 16'(s4_west_reg) * 16'd7;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_days_reg <= s4_days_reg;
            s5_yest_reg <= s4_yest_reg;
            s5_st0_reg  <= ecd_pkg::year_start(s4_yest_reg);
            s5_st1_reg  <= ecd_pkg::year_start(s4_yest_reg + 8'd1);
            s5_st2_reg  <= ecd_pkg::year_start(s4_yest_reg + 8'd2);
            s5_hest_reg <= s4_hest_reg;
            s5_hr_reg   <= p5_hdiff[12:0];
            s5_mest_reg <= s4_mest_reg;
            s5_sr_reg   <= p5_mdiff[6:0];
            s5_wr_reg   <= p5_wdiff[3:0];
        end
    end

    // ---------------- stage 6: pick year, correct hour/minute/weekday
    logic [7:0]  p6_ofs;
    logic [16:0] p6_start;
    logic [16:0] p6_left;
    logic [4:0]  p6_hour;
    logic [10:0] p6_tmin;
    logic [5:0]  p6_sec;
    logic [2:0]  p6_wday;
    logic [7:0]  s6_ofs_reg;
    logic [8:0]  s6_left_reg;
    logic [4:0]  s6_hour_reg;
    logic [10:0] s6_tmin_reg;
    logic [5:0]  s6_sec_reg;
    logic [2:0]  s6_wday_reg;

    always_comb
    begin
        if (17'(s5_days_reg) >= s5_st2_reg)
        begin
            p6_ofs   = s5_yest_reg + 8'd2;
            p6_start = s5_st2_reg;
        end
        else if (17'(s5_days_reg) >= s5_st1_reg)
        begin
            p6_ofs   = s5_yest_reg + 8'd1;
            p6_start = s5_st1_reg;
        end
        else
        begin
            p6_ofs   = s5_yest_reg;
            p6_start = s5_st0_reg;
        end
        p6_left = 17'(s5_days_reg) - p6_start;

        p6_hour = (s5_hr_reg >= 13'd3600) ? s5_hest_reg + 5'd1 : s5_hest_reg;

        if (s5_sr_reg >= 7'd60)
        begin
            p6_tmin = s5_mest_reg + 11'd1;
            p6_sec  = 6'(s5_sr_reg - 7'd60);
        end
        else
        begin
            p6_tmin = s5_mest_reg;
            p6_sec  = s5_sr_reg[5:0];
        end

        p6_wday = (s5_wr_reg >= 4'd7) ? 3'(s5_wr_reg - 4'd7) : s5_wr_reg[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_ofs_reg  <= p6_ofs;
            s6_left_reg <= p6_left[8:0];
            s6_hour_reg <= p6_hour;
            s6_tmin_reg <= p6_tmin;
            s6_sec_reg  <= p6_sec;
            s6_wday_reg <= p6_wday;
        end
    end

    // ---------------- stage 7: month and day, minute of hour
    logic        p7_leap;
    logic [3:0]  p7_month;
    logic [8:0]  p7_base;
    logic [8:0]  p7_day;
    logic [10:0] p7_min;
    ecd_pkg::date_t s7_date_reg;

    always_comb
    begin
        logic [8:0] cs;
        // year 1978+ofs is leap when divisible by 4, except 2100
        p7_leap  = ((s6_ofs_reg + 8'd2) & 8'd3) == 8'd0 && s6_ofs_reg != 8'd122;
        p7_month = 4'd1;
        p7_base  = 9'd0;
        for (int k = 2; k <= 12; k++)
        begin
            cs = ecd_pkg::cum_days(4'(k)) + 9'(p7_leap && k >= 3);
            if (s6_left_reg >= cs)
            begin
                p7_month = 4'(k);
                p7_base  = cs;
            end
        end
        p7_day = s6_left_reg - p7_base + 9'd1;
        p7_min = s6_tmin_reg - 11'(s6_hour_reg) * 11'd60;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_date_reg.second  <= s6_sec_reg;
            s7_date_reg.minute  <= p7_min[5:0];
            s7_date_reg.hour    <= s6_hour_reg;
            s7_date_reg.day     <= p7_day[4:0];
            s7_date_reg.month   <= p7_month;
            s7_date_reg.year    <= ecd_pkg::EPOCH_YEAR12 + 12'(s6_ofs_reg);
            s7_date_reg.weekday <= s6_wday_reg;
        end
    end

    assign date = s7_date_reg;

endmodule

// ===== sv/ecd_join.sv =====
// ============================================================================
// ecd_join
// Calendar fields to seconds count with optional range checks, seven stages.
// ============================================================================
`timescale 1ns / 1ps

module ecd_join
(
    input  logic               clk,
    input  logic               en,
    input  logic [1:0]         action,
    input  logic [15:0]        second,
    input  logic [15:0]        minute,
    input  logic [15:0]        hour,
    input  logic [15:0]        day,
    input  logic [15:0]        month,
    input  logic [15:0]        year,
    input  logic [15:0]        weekday,
    output ecd_pkg::secs_res_t res
);

    // ---------------- stage 1: divide-by-25 estimates, time products
    logic [15:0] p1_y1;
    logic [28:0] p1_c100;
    logic [26:0] p1_c400;
    logic [28:0] p1_y100;
    logic [26:0] p1_y400;

    logic [1:0]  s1_act_reg;
    logic [15:0] s1_sec_reg;
    logic [15:0] s1_min_reg;
    logic [15:0] s1_hour_reg;
    logic [15:0] s1_day_reg;
    logic [15:0] s1_month_reg;
    logic [15:0] s1_year_reg;
    logic [15:0] s1_wday_reg;
    logic [27:0] s1_h3600_reg;
    logic [21:0] s1_m60_reg;
    logic [9:0]  s1_c100_reg;
    logic [7:0]  s1_c400_reg;
    logic [9:0]  s1_y100_reg;
    logic [7:0]  s1_y400_reg;

    assign p1_y1   = year - 16'd1;
    assign p1_c100 = 29'(p1_y1[15:2]) * 29'(ecd_pkg::RCP_25);
    assign p1_c400 = 27'(p1_y1[15:4]) * 27'(ecd_pkg::RCP_25);
    assign p1_y100 = 29'(year[15:2]) * 29'(ecd_pkg::RCP_25);
    assign p1_y400 = 27'(year[15:4]) * 27'(ecd_pkg::RCP_25);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_act_reg   <= action;
            s1_sec_reg   <= second;
            s1_min_reg   <= minute;
            s1_hour_reg  <= hour;
            s1_day_reg   <= day;
            s1_month_reg <= month;
            s1_year_reg  <= year;
            s1_wday_reg  <= weekday;
            s1_h3600_reg <= 28'(hour) * 28'd3600;
            s1_m60_reg   <= 22'(minute) * 22'd60;
            s1_c100_reg  <= p1_c100[28:19];
            s1_c400_reg  <= p1_c400[26:19];
            s1_y100_reg  <= p1_y100[28:19];
            s1_y400_reg  <= p1_y400[26:19];
        end
    end

    // ---------------- stage 2: leap count, year days, leap flag, checks
    logic [15:0] p2_y1;
    logic [13:0] p2_leaps;
    logic [15:0] p2_yofs;
    logic [13:0] p2_r100;
    logic [11:0] p2_r400;
    logic        p2_leap;
    logic        p2_chk;

    logic [1:0]  s2_act_reg;
    logic [24:0] s2_yd_reg;
    logic [13:0] s2_leaps_reg;
    logic        s2_gt_reg;
    logic        s2_leap_reg;
    logic        s2_chk_reg;
    logic [31:0] s2_hms_reg;
    logic [15:0] s2_day_reg;
    logic [15:0] s2_month_reg;

    always_comb
    begin
        p2_y1    = s1_year_reg - 16'd1;
        p2_leaps = p2_y1[15:2] - 14'(s1_c100_reg) + 14'(s1_c400_reg);
        p2_yofs  = s1_year_reg - ecd_pkg::EPOCH_YEAR;
        p2_r100  = s1_year_reg[15:2] - 14'(s1_y100_reg) * 14'd25;
        p2_r400  = s1_year_reg[15:4] - 12'(s1_y400_reg) * 12'd25;
        p2_leap  = s1_year_reg[1:0] == 2'd0 &&
                   (p2_r100 != 14'd0 || (s1_year_reg[3:0] == 4'd0 && p2_r400 == 12'd0));
        p2_chk   = s1_sec_reg <= 16'd60 && s1_min_reg <= 16'd59 &&
                   s1_hour_reg <= 16'd23 && s1_year_reg >= ecd_pkg::EPOCH_YEAR &&
                   s1_wday_reg <= 16'd6 && s1_day_reg >= 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_act_reg   <= s1_act_reg;
            s2_yd_reg    <= 25'(p2_yofs) * 25'd365;
            s2_leaps_reg <= p2_leaps;
            s2_gt_reg    <= s1_year_reg > ecd_pkg::EPOCH_YEAR;
            s2_leap_reg  <= p2_leap;
            s2_chk_reg   <= p2_chk;
            s2_hms_reg   <= 32'(s1_h3600_reg) + 32'(s1_m60_reg) + 32'(s1_sec_reg);
            s2_day_reg   <= s1_day_reg;
            s2_month_reg <= s1_month_reg;
        end
    end

    // ---------------- stage 3: days before year and month, validity
    logic [3:0]  p3_m;
    logic        p3_mon_ok;
    logic [4:0]  p3_dim;
    logic [8:0]  p3_cum;
    logic        p3_ok;

    logic [24:0] s3_dy_reg;
    logic [8:0]  s3_cum_reg;
    logic [15:0] s3_day_reg;
    logic [31:0] s3_hms_reg;
    logic        s3_ok_reg;

    always_comb
    begin
        p3_m      = s2_month_reg[3:0];
        p3_mon_ok = s2_month_reg >= 16'd1 && s2_month_reg <= 16'd12;
        p3_cum    = ecd_pkg::cum_days(p3_m) + 9'(s2_leap_reg && p3_m > 4'd2);
        p3_dim    = ecd_pkg::month_len(p3_m) + 5'(s2_leap_reg && p3_m == 4'd2);
        p3_ok     = p3_mon_ok &&
                    (s2_act_reg == ecd_pkg::ACT_TO_SECS ||
                     (s2_chk_reg && s2_day_reg <= 16'(p3_dim)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dy_reg  <= s2_gt_reg ?
                          s2_yd_reg + 25'(s2_leaps_reg) - 25'(ecd_pkg::EPOCH_LEAPS) : 25'd0;
            s3_cum_reg <= p3_cum;
            s3_day_reg <= s2_day_reg;
            s3_hms_reg <= s2_hms_reg;
            s3_ok_reg  <= p3_ok;
        end
    end

    // ---------------- stage 4: total day count (wraps)
    logic [31:0] s4_days_reg;
    logic [31:0] s4_hms_reg;
    logic        s4_ok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_days_reg <= 32'(s3_dy_reg) + 32'(s3_cum_reg) + 32'(s3_day_reg) - 32'd1;
            s4_hms_reg  <= s3_hms_reg;
            s4_ok_reg   <= s3_ok_reg;
        end
    end

    // ---------------- stage 5: days to seconds
    logic [31:0] s5_prod_reg;
    logic [31:0] s5_hms_reg;
    logic        s5_ok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_prod_reg <= s4_days_reg * 32'd86400;
            s5_hms_reg  <= s4_hms_reg;
            s5_ok_reg   <= s4_ok_reg;
        end
    end

    // ---------------- stage 6: add time of day
    logic [31:0] s6_sum_reg;
    logic        s6_ok_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_sum_reg <= s5_prod_reg + s5_hms_reg;
            s6_ok_reg  <= s5_ok_reg;
        end
    end

    // ---------------- stage 7: zero rejected dates
    ecd_pkg::secs_res_t s7_res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_res_reg.seconds <= s6_ok_reg ? s6_sum_reg : 32'd0;
            s7_res_reg.ok      <= s6_ok_reg;
        end
    end

    assign res = s7_res_reg;

endmodule

// ===== sim/epoch_seconds_date_convert_checker.sv =====
// ============================================================================
// epoch_seconds_date_convert_checker
// Watches both channels of the epoch/date converter, computes the expected
// result of every accepted input transfer and compares it field by field
// with the transfers leaving the block.
// ============================================================================
`timescale 1ns / 1ps

module epoch_seconds_date_convert_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] in_seconds,
    input  logic [15:0] in_second,
    input  logic [15:0] in_minute,
    input  logic [15:0] in_hour,
    input  logic [15:0] in_day,
    input  logic [15:0] in_month,
    input  logic [15:0] in_year,
    input  logic [15:0] in_weekday,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_seconds,
    input  logic [5:0]  out_second,
    input  logic [5:0]  out_minute,
    input  logic [4:0]  out_hour,
    input  logic [4:0]  out_day,
    input  logic [3:0]  out_month,
    input  logic [11:0] out_year,
    input  logic [2:0]  out_weekday,
    input  logic        valid_res,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          rejects_seen
);

    typedef struct packed {
        logic [31:0] seconds;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        logic        ok;
    } conv_res_t;

    conv_res_t expected_q[$];

    function automatic bit is_leap_yr(input int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned days_in_mon(input int unsigned y, input int unsigned m);
        int unsigned lens[12];
        int unsigned d;
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        d = lens[(m - 1) % 12];
        if (m == 2 && is_leap_yr(y))
            d = d + 1;
        return d;
    endfunction

    function automatic int unsigned leap_count(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Expected result of one conversion; all arithmetic mod 2^32
    function automatic conv_res_t convert(input logic [1:0] act, input logic [31:0] secs,
                                          input int unsigned sec, input int unsigned mn,
                                          input int unsigned hr, input int unsigned md,
                                          input int unsigned mo, input int unsigned yr,
                                          input int unsigned wd);
        conv_res_t r;
        int unsigned days, rem, left, y, m;
        bit ok;
        r = '0;
        if (act == ecd_pkg::ACT_TO_DATE) begin
            days = secs / 86400;
            rem  = secs % 86400;
            left = days;
            y = 1978;
            m = 1;
            while (left >= (is_leap_yr(y) ? 366 : 365)) begin
                left = left - (is_leap_yr(y) ? 366 : 365);
                y++;
            end
            while (m < 12 && left >= days_in_mon(y, m)) begin
                left = left - days_in_mon(y, m);
                m++;
            end
            r.second  = 6'(rem % 60);
            r.minute  = 6'((rem / 60) % 60);
            r.hour    = 5'(rem / 3600);
            r.day     = 5'(left + 1);
            r.month   = 4'(m);
            r.year    = 12'(y);
            r.weekday = 3'(days % 7);
            r.ok      = 1'b1;
        end else if (act == ecd_pkg::ACT_TO_SECS || act == ecd_pkg::ACT_TO_SECS_CHK) begin
            ok = (mo >= 1 && mo <= 12);
            if (ok && act == ecd_pkg::ACT_TO_SECS_CHK) begin
                if (sec > 60 || mn > 59 || hr > 23 || yr < 1978 || wd > 6 || md < 1 ||
                    md > days_in_mon(yr, mo))
                    ok = 0;
            end
            if (ok) begin
                days = 0;
                if (yr > 1978)
                    days = 365 * (yr - 1978) + leap_count(yr - 1) - leap_count(1977);
                for (int unsigned k = 1; k < mo; k++)
                    days = days + days_in_mon(yr, k);
                days = days + md - 1;
                r.seconds = days * 86400 + hr * 3600 + mn * 60 + sec;
                r.ok = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    // Predict on input transfer, compare on output transfer
    always @(posedge clk or negedge rst_n)
    begin
        conv_res_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_count = 0;
            results_seen <= 0;
            rejects_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(convert(action, in_seconds, in_second, in_minute,
                                             in_hour, in_day, in_month, in_year,
                                             in_weekday));
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (!valid_res)
                    rejects_seen <= rejects_seen + 1;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result transfer", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_seconds !== want.seconds)
                        report_mismatch("out_seconds", out_seconds, want.seconds);
                    if (out_second !== want.second)
                        report_mismatch("out_second", out_second, want.second);
                    if (out_minute !== want.minute)
                        report_mismatch("out_minute", out_minute, want.minute);
                    if (out_hour !== want.hour)
                        report_mismatch("out_hour", out_hour, want.hour);
                    if (out_day !== want.day)
                        report_mismatch("out_day", out_day, want.day);
                    if (out_month !== want.month)
                        report_mismatch("out_month", out_month, want.month);
                    if (out_year !== want.year)
                        report_mismatch("out_year", out_year, want.year);
                    if (out_weekday !== want.weekday)
                        report_mismatch("out_weekday", out_weekday, want.weekday);
                    if (valid_res !== want.ok)
                        report_mismatch("valid_res", valid_res, want.ok);
                end
            end
        end
    end

endmodule

// ===== sim/epoch_seconds_date_convert_tb.sv =====
// ============================================================================
// epoch_seconds_date_convert_tb
// Drives directed edge dates and random conversions of all four action codes
// through the converter under several idle and stall patterns; the checker
// beside the block predicts and compares every result.
// ============================================================================
`timescale 1ns / 1ps

module epoch_seconds_date_convert_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] in_seconds;
    logic [15:0] in_second, in_minute, in_hour, in_day, in_month, in_year, in_weekday;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_seconds;
    logic [5:0]  out_second, out_minute;
    logic [4:0]  out_hour, out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [2:0]  out_weekday;
    logic        valid_res;
    int          fail_count, pending, results_seen, rejects_seen;
    int          send_idle_pct, recv_stall_pct;
    int          sent;

    epoch_seconds_date_convert uut (.*);

    epoch_seconds_date_convert_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // One transfer, with optional idle cycles before it
    task automatic send_item(input logic [1:0] act, input logic [31:0] secs,
                             input logic [15:0] s, input logic [15:0] mn,
                             input logic [15:0] h, input logic [15:0] d,
                             input logic [15:0] mo, input logic [15:0] y,
                             input logic [15:0] wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        in_seconds <= secs;
        in_second  <= s;
        in_minute  <= mn;
        in_hour    <= h;
        in_day     <= d;
        in_month   <= mo;
        in_year    <= y;
        in_weekday <= wd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Random item: mostly plausible dates, sometimes full-width noise
    task automatic send_random();
        logic [1:0]  act;
        logic [15:0] y, mo, d;
        act = 2'($urandom_range(3));
        if ($urandom_range(9) < 7)
        begin
            y  = 16'($urandom_range(1970, 2120));
            mo = 16'($urandom_range(1, 12));
            d  = 16'($urandom_range(0, 32));
            send_item(act, $urandom, 16'($urandom_range(61)), 16'($urandom_range(60)),
                      16'($urandom_range(24)), d, mo, y, 16'($urandom_range(7)));
        end
        else
            send_item(act, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom_range(13) == 0 ? $urandom :
                      $urandom_range(0, 13)), 16'($urandom), 16'($urandom));
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ecd_pkg::ACT_TO_DATE;
        in_seconds = '0;
        {in_second, in_minute, in_hour, in_day, in_month, in_year, in_weekday} = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, leap days, rejects, unknown action
        send_item(ecd_pkg::ACT_TO_DATE, 32'd0, 0, 0, 0, 0, 0, 0, 0);
        send_item(ecd_pkg::ACT_TO_DATE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_item(ecd_pkg::ACT_TO_DATE, 32'd68169599, 0, 0, 0, 0, 0, 0, 0);
        send_item(ecd_pkg::ACT_TO_DATE, 32'd4039372800, 0, 0, 0, 0, 0, 0, 0);
        send_item(ecd_pkg::ACT_TO_SECS, '0, 0, 0, 0, 1, 1, 1978, 0);
        send_item(ecd_pkg::ACT_TO_SECS, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12,
                  16'hFFFF, 16'hFFFF);
        send_item(ecd_pkg::ACT_TO_SECS, '0, 5, 5, 5, 0, 3, 1900, 0);
        send_item(ecd_pkg::ACT_TO_SECS, '0, 0, 0, 0, 1, 0, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS, '0, 0, 0, 0, 1, 13, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 60, 59, 23, 29, 2, 2000, 6);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 29, 2, 2100, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 29, 2, 2024, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 61, 0, 0, 1, 1, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 60, 0, 1, 1, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 24, 1, 1, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 1, 1, 1977, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 1, 1, 2000, 7);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 0, 1, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 31, 4, 2000, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 31, 12, 2200, 0);
        send_item(ecd_pkg::ACT_TO_SECS_CHK, '0, 0, 0, 0, 1, 16'hFFFF, 16'hFFFF, 0);
        send_item(ecd_pkg::ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Hold off until everything is back before the random part
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            repeat (310)
                send_random();
        end
        drain();
        repeat (3 * ecd_pkg::PIPE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d transfers; %0d results checked, %0d of them rejected or unknown.",
                 sent, results_seen, rejects_seen);
        $display("Covered all actions, leap and century years, and four idle/stall mixes.");
        if (fail_count == 0)
            $display("** epoch_seconds_date_convert: PASSED **");
        else
            $display("** epoch_seconds_date_convert: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("** epoch_seconds_date_convert: FAILED **");
        $finish;
    end

endmodule
